/* sv/median_sweep_nearest_target_defines.svh */
// Assertion macros shared by the RTL of the nearest-target sweep filter.
`ifndef MEDIAN_SWEEP_NEAREST_TARGET_DEFINES_SVH
`define MEDIAN_SWEEP_NEAREST_TARGET_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define MSNT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define MSNT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/msnt_pkg.sv */
// Package with shared types, widths and constants of the nearest-target sweep filter.
`default_nettype none
package msnt_pkg;

  localparam int DIST_W        = 16;
  localparam int ANGLE_W       = 8;
  localparam int CENTER_W      = 8;
  localparam int SPAN_W        = 7;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 8;
  localparam int SAMPLES_DEF   = 5;
  localparam int POSITIONS_DEF = 9;

  // 3000 cm expressed in 1/16 cm.
  localparam logic [DIST_W-1:0] FAR_LIMIT = 16'd48000;

  localparam logic [CENTER_W-1:0] CENTER_RESET = 8'd85;
  localparam logic [SPAN_W-1:0]   SPAN_RESET   = 7'd85;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_ANGLE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_HALF_SPAN = 2'd1;

  typedef struct packed {
    logic [CENTER_W-1:0] center;
    logic [SPAN_W-1:0]   span;
  } sweep_cfg_t;

endpackage
`default_nettype wire

/* sv/median_sweep_nearest_target.sv */
// Nearest-target sweep filter: per-position median over a sweep, least median and its angle.
//
// Input beats on in_distance_sample (1/16 cm) are taken at any edge with in_valid high
// and in_stall low. Every SAMPLES beats form one sweep position; the samples are sorted
// as they arrive in a chain of SAMPLES cells, one cell per stored sample, and the
// middle cell gives the position's median. One beat is taken per cycle within a sweep.
// After the last sample of a position, the median and the position's angle go through
// a three-stage pipeline (median capture, angle multiply, compare and update).
// After POSITIONS positions one result beat appears on out_nearest_distance and
// out_nearest_angle, registered from the compare and update stage. From the last
// input beat until the result beat is taken, in_stall stays high; a receiver that
// holds out_stall high keeps the result in the output register and the input side
// waits with it.
// Configuration: cfg_index 0 is the center angle, 1 is the sweep half span; cfg_ready is
// always high and other indexes are ignored. A write applies from the next completed
// position.
// Synchronous reset (rst_n low) empties the sample chain, clears the counters, sets the
// best distance to 3000 cm and the best angle to 0 and restores register defaults.
`default_nettype none
module median_sweep_nearest_target
  import msnt_pkg::*;
#(
  parameter int SAMPLES   = SAMPLES_DEF,
  parameter int POSITIONS = POSITIONS_DEF
)(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [DIST_W-1:0]     in_distance_sample,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [DIST_W-1:0]          out_nearest_distance,
  output logic [ANGLE_W-1:0]         out_nearest_angle,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

`include "median_sweep_nearest_target_defines.svh"

  localparam int CNT_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int POS_W = $clog2(POSITIONS);
  localparam int MID   = SAMPLES / 2;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES - 1);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(POSITIONS - 1);

  sweep_cfg_t          cfg_r;
  sweep_cfg_t          cfg_nxt;
  logic [CNT_W-1:0]    cnt_r;
  logic [CNT_W-1:0]    cnt_nxt;
  logic [POS_W-1:0]    pos_r;
  logic [POS_W-1:0]    pos_nxt;
  logic                done_r;
  logic                done_last_r;
  logic [POS_W-1:0]    done_pos_r;
  logic                v1_r;
  logic                last1_r;
  logic [DIST_W-1:0]   med1_r;
  logic                v2_r;
  logic                last2_r;
  logic [DIST_W-1:0]   med2_r;
  logic [DIST_W-1:0]   best_dist_r;
  logic [DIST_W-1:0]   best_dist_nxt;
  logic [ANGLE_W-1:0]  best_angle_r;
  logic [ANGLE_W-1:0]  best_angle_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic [DIST_W-1:0]   out_dist_r;
  logic [ANGLE_W-1:0]  out_angle_r;
  logic                in_take;
  logic                group_end;
  logic                new_best;
  logic [ANGLE_W-1:0]  pos_angle;

  logic [DIST_W-1:0]   cell_val [SAMPLES];
  logic [SAMPLES-1:0]  cell_gt;

  assign cfg_ready = 1'b1;
  assign in_take   = in_valid && !in_stall;
  assign group_end = in_take && (cnt_r == CNT_LAST);

  // Hold input off from the last beat of a sweep until its result has been taken.
  assign in_stall = out_valid_r || (done_r && done_last_r) || (v1_r && last1_r)
                 || (v2_r && last2_r);

  for (genvar i = 0; i < SAMPLES; i++) begin : g_cell
    logic occ;
    assign occ = cnt_r > CNT_W'(i);
    if (i == 0) begin : g_head
      msnt_cell u_cell (
        .clk      (clk),
        .ins_en   (in_take),
        .sample   (in_distance_sample),
        .occupied (occ),
        .left_gt  (1'b0),
        .left_val (in_distance_sample),
        .gt       (cell_gt[i]),
        .val      (cell_val[i])
      );
    end else begin : g_body
      msnt_cell u_cell (
        .clk      (clk),
        .ins_en   (in_take),
        .sample   (in_distance_sample),
        .occupied (occ),
        .left_gt  (cell_gt[i-1]),
        .left_val (cell_val[i-1]),
        .gt       (cell_gt[i]),
        .val      (cell_val[i])
      );
    end
  end

  msnt_angle #(
    .POSITIONS (POSITIONS)
  ) u_angle (
    .clk   (clk),
    .load  (done_r),
    .pos   (done_pos_r),
    .cfg   (cfg_r),
    .angle (pos_angle)
  );

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CENTER_ANGLE:    cfg_nxt.center = cfg_data;
        REG_SWEEP_HALF_SPAN: cfg_nxt.span   = cfg_data[SPAN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    pos_nxt = pos_r;
    if (in_take) begin
      cnt_nxt = group_end ? '0 : cnt_r + 1'b1;
    end
    if (group_end) begin
      pos_nxt = (pos_r == POS_LAST) ? '0 : pos_r + 1'b1;
    end
  end

  // A median equal to the best so far also wins, so ties go to the later position.
  assign new_best = best_dist_r >= med2_r;

  always_comb begin
    best_dist_nxt  = best_dist_r;
    best_angle_nxt = best_angle_r;
    out_valid_nxt  = out_valid_r && out_stall;
    if (v2_r) begin
      if (new_best) begin
        best_dist_nxt  = med2_r;
        best_angle_nxt = pos_angle;
      end
      if (last2_r) begin
        out_valid_nxt = 1'b1;
        best_dist_nxt = FAR_LIMIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center <= CENTER_RESET;
      cfg_r.span   <= SPAN_RESET;
      cnt_r        <= '0;
      pos_r        <= '0;
      done_r       <= 1'b0;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      best_dist_r  <= FAR_LIMIT;
      best_angle_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      cfg_r        <= cfg_nxt;
      cnt_r        <= cnt_nxt;
      pos_r        <= pos_nxt;
      done_r       <= group_end;
      v1_r         <= done_r;
      v2_r         <= v1_r;
      best_dist_r  <= best_dist_nxt;
      best_angle_r <= best_angle_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (group_end) begin
      done_pos_r  <= pos_r;
      done_last_r <= pos_r == POS_LAST;
    end
    if (done_r) begin
      med1_r  <= cell_val[MID];
      last1_r <= done_last_r;
    end
    med2_r  <= med1_r;
    last2_r <= last1_r;
    if (v2_r && last2_r) begin
      out_dist_r  <= new_best ? med2_r : best_dist_r;
      out_angle_r <= new_best ? pos_angle : best_angle_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_nearest_distance = out_dist_r;
  assign out_nearest_angle    = out_angle_r;

  `MSNT_ASSERT_NOW(a_result_blocks_input, out_valid_r, in_stall,
    "input taken while a result beat waits")
  `MSNT_ASSERT_NOW(a_count_in_range, 1'b1, cnt_r <= CNT_LAST,
    "sample count beyond the group size")
  `MSNT_ASSERT_NEXT(a_group_end_flags_median, group_end, done_r && (cnt_r == '0),
    "completed group did not start the median stage")
  `MSNT_ASSERT_NEXT(a_sweep_end_gives_result, v2_r && last2_r, out_valid_r,
    "end of sweep produced no result beat")

endmodule
`default_nettype wire

/* sv/msnt_cell.sv */
// One cell of the insertion chain that keeps the current position's samples sorted.
`default_nettype none
module msnt_cell
  import msnt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              ins_en,
  input  wire logic [DIST_W-1:0] sample,
  input  wire logic              occupied,
  input  wire logic              left_gt,
  input  wire logic [DIST_W-1:0] left_val,
  output logic                   gt,
  output logic [DIST_W-1:0]      val
);

  logic [DIST_W-1:0] val_r;
  logic [DIST_W-1:0] val_nxt;

  // An empty cell counts as larger than any sample.
  assign gt  = !occupied || (val_r > sample);
  assign val = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ins_en && gt) begin
      val_nxt = left_gt ? left_val : sample;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule
`default_nettype wire

/* sv/msnt_angle.sv */
// Angle unit: servo angle of a sweep position over two pipeline stages.
`default_nettype none
module msnt_angle
  import msnt_pkg::*;
#(
  parameter int POSITIONS = POSITIONS_DEF
)(
  input  wire logic                         clk,
  input  wire logic                         load,
  input  wire logic [$clog2(POSITIONS)-1:0] pos,
  input  wire sweep_cfg_t                   cfg,
  output logic [ANGLE_W-1:0]                angle
);

  localparam int POS_W  = $clog2(POSITIONS);
  localparam int N_W    = POS_W + SPAN_W + 1;
  localparam int SH     = N_W + $clog2(POSITIONS);
  localparam int PROD_W = N_W + SH + 1;
  // Rounded-up reciprocal of POSITIONS-1; exact quotient for every n below 2**N_W.
  localparam logic [SH:0] RECIP = (SH+1)'(((2 ** SH) + POSITIONS - 2) / (POSITIONS - 1));

  logic [N_W-1:0]      n_r;
  sweep_cfg_t          cfg_a_r;
  sweep_cfg_t          cfg_b_r;
  logic [ANGLE_W-1:0]  q_r;
  logic [PROD_W-1:0]   prod;
  logic signed [10:0]  sum;

  assign prod = PROD_W'(n_r) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (load) begin
      n_r     <= N_W'({pos, 1'b0}) * N_W'(cfg.span);
      cfg_a_r <= cfg;
    end
    q_r     <= prod[SH +: ANGLE_W];
    cfg_b_r <= cfg_a_r;
  end

  always_comb begin
    sum = $signed({3'b000, cfg_b_r.center}) - $signed({4'b0000, cfg_b_r.span})
        + $signed({3'b000, q_r});
    if (sum < 0) begin
      angle = '0;
    end else if (sum > 11'sd255) begin
      angle = '1;
    end else begin
      angle = sum[ANGLE_W-1:0];
    end
  end

endmodule
`default_nettype wire

/* tb/median_sweep_nearest_target_tb.sv */
// Self-checking testbench for the nearest-target sweep filter, with a built-in sweep predictor.
`timescale 1ns / 100ps
module median_sweep_nearest_target_tb;
  import msnt_pkg::*;

  localparam int N_SAMPLES     = SAMPLES_DEF;
  localparam int N_POSITIONS   = POSITIONS_DEF;
  localparam int SWEEP_BEATS   = N_SAMPLES * N_POSITIONS;
  localparam int RANDOM_ITEMS  = 1875;
  localparam int SETTLE_CYCLES = 12;
  localparam int IDLE_LIMIT    = 2000;
  localparam int N_PLANS       = 8;
  localparam int N_STYLES      = 6;

  localparam logic [CFG_IDX_W-1:0] FIRST_UNUSED_REG = REG_SWEEP_HALF_SPAN + 1'b1;
  localparam logic [CFG_IDX_W-1:0] LAST_UNUSED_REG  = '1;

  typedef enum int {
    STYLE_FULL_RANGE,
    STYLE_NEAR_FAR_LIMIT,
    STYLE_CLOSE,
    STYLE_TIES,
    STYLE_BEYOND_LIMIT,
    STYLE_OUTLIERS
  } sweep_style_t;

  typedef struct {
    logic [DIST_W-1:0]  distance;
    logic [ANGLE_W-1:0] angle;
  } sweep_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [DIST_W-1:0]     in_distance_sample = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [DIST_W-1:0]     out_nearest_distance;
  logic [ANGLE_W-1:0]    out_nearest_angle;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_CENTER_ANGLE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [DIST_W-1:0] pending_samples[$];
  sweep_result_t     expected_sweeps[$];
  sweep_result_t     want;

  bit in_gaps_on = 1'b1;
  bit out_stalls_on = 1'b1;
  int in_gap_left = 0;
  int out_stall_left = 0;
  int idle_cycles = 0;
  int error_count = 0;

  // Predictor state, mirroring the block.
  logic [DIST_W-1:0]   position_samples[N_SAMPLES];
  int                  samples_taken;
  int                  positions_done;
  logic [DIST_W-1:0]   sweep_min_dist;
  logic [ANGLE_W-1:0]  sweep_min_angle;
  logic [CENTER_W-1:0] pred_center;
  logic [SPAN_W-1:0]   pred_span;

  median_sweep_nearest_target u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_distance_sample   (in_distance_sample),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_nearest_distance (out_nearest_distance),
    .out_nearest_angle    (out_nearest_angle),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int random_idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 88) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  function automatic logic [DIST_W-1:0] draw_sample(sweep_style_t style,
                                                    logic [DIST_W-1:0] tie_value);
    unique case (style)
      STYLE_NEAR_FAR_LIMIT: return DIST_W'($urandom_range(FAR_LIMIT - 5, FAR_LIMIT + 5));
      STYLE_CLOSE:          return DIST_W'($urandom_range(0, FAR_LIMIT - 1));
      STYLE_TIES:           return tie_value;
      STYLE_BEYOND_LIMIT:   return DIST_W'($urandom_range(FAR_LIMIT + 1, 16'hFFFF));
      STYLE_OUTLIERS: begin
        if ($urandom_range(0, 4) < 2) return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        return DIST_W'($urandom_range(1000, 60000));
      end
      default:              return DIST_W'($urandom);
    endcase
  endfunction

  // Takes one accepted sample; at the end of a sweep queues the expected result.
  function automatic void update_sweep_prediction(logic [DIST_W-1:0] sample);
    logic [DIST_W-1:0] sorted[N_SAMPLES];
    logic [DIST_W-1:0] key;
    logic [DIST_W-1:0] median;
    int center;
    int span;
    int angle;
    int j;
    position_samples[samples_taken] = sample;
    samples_taken++;
    if (samples_taken < N_SAMPLES) return;
    samples_taken = 0;
    sorted = position_samples;
    for (int i = 1; i < N_SAMPLES; i++) begin
      key = sorted[i];
      j = i - 1;
      while (j >= 0 && sorted[j] > key) begin
        sorted[j + 1] = sorted[j];
        j--;
      end
      sorted[j + 1] = key;
    end
    median = sorted[N_SAMPLES / 2];
    // An equal median also wins, so ties go to the later position.
    if (median <= sweep_min_dist) begin
      center = pred_center;
      span = pred_span;
      angle = center - span + (2 * positions_done * span) / (N_POSITIONS - 1);
      if (angle < 0) angle = 0;
      if (angle > 255) angle = 255;
      sweep_min_dist = median;
      sweep_min_angle = angle[ANGLE_W-1:0];
    end
    positions_done++;
    if (positions_done == N_POSITIONS) begin
      expected_sweeps.push_back('{sweep_min_dist, sweep_min_angle});
      positions_done = 0;
      sweep_min_dist = FAR_LIMIT;
    end
  endfunction

  // Input driver: one beat per accepted handshake, random gaps between beats.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap_left <= 0;
    end else if (!in_valid || !in_stall) begin
      if (in_gap_left != 0) begin
        in_valid <= 1'b0;
        in_gap_left <= in_gap_left - 1;
      end else if (pending_samples.size() != 0) begin
        in_valid <= 1'b1;
        in_distance_sample <= pending_samples.pop_front();
        in_gap_left <= in_gaps_on ? random_idle_len() : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_stall_left <= 0;
    end else if (out_stall_left != 0) begin
      out_stall <= 1'b1;
      out_stall_left <= out_stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      out_stall_left <= out_stalls_on ? random_idle_len() : 0;
    end
  end

  // Monitor: tracks register writes and accepted samples, checks result beats.
  always @(posedge clk) begin
    if (!rst_n) begin
      pred_center = CENTER_RESET;
      pred_span = SPAN_RESET;
      samples_taken = 0;
      positions_done = 0;
      sweep_min_dist = FAR_LIMIT;
      sweep_min_angle = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_CENTER_ANGLE:    pred_center = cfg_data;
          REG_SWEEP_HALF_SPAN: pred_span = cfg_data[SPAN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) update_sweep_prediction(in_distance_sample);
      if (out_valid && !out_stall) begin
        if (expected_sweeps.size() == 0) begin
          $error("result beat with none expected: nearest_distance %0d, nearest_angle %0d",
                 out_nearest_distance, out_nearest_angle);
          error_count++;
        end else begin
          want = expected_sweeps.pop_front();
          if (out_nearest_distance !== want.distance) begin
            $error("nearest_distance: expected %0d, actual %0d",
                   want.distance, out_nearest_distance);
            error_count++;
          end
          if (out_nearest_angle !== want.angle) begin
            $error("nearest_angle: expected %0d, actual %0d", want.angle, out_nearest_angle);
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog on cycles in which no beat of any channel is accepted.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[median_sweep_nearest_target] ERROR");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Holds off until every queued sample is taken and every expected result has come,
  // then lets the position pipeline settle.
  task automatic wait_until_drained();
    while (pending_samples.size() != 0 || in_valid || expected_sweeps.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] center_plan[N_PLANS];
    logic [CFG_DATA_W-1:0] span_plan[N_PLANS];
    logic [CFG_DATA_W-1:0] new_center;
    logic [CFG_DATA_W-1:0] new_span;
    logic [DIST_W-1:0]     tie_value;
    sweep_style_t          style;
    int generated;
    int break_at;
    int plan_idx;

    // Extremes first: negative angles clamp to 0, wide settings saturate at 255,
    // and a span byte with its top bit set shows the register keeps only 7 bits.
    center_plan = '{8'd0,  8'd180, 8'd255, 8'd0, 8'd255, 8'd180, 8'd90, 8'd0};
    span_plan   = '{8'd90, 8'd90,  8'hFF,  8'd0, 8'd0,   8'd127, 8'd45, 8'd127};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed positions under the reset settings. The first median equals the
    // 3000 cm start value and must still win; then alternating bit patterns, a tie,
    // a far position and an all-zero position.
    pending_samples.push_back(16'd0);
    pending_samples.push_back(16'hFFFF);
    pending_samples.push_back(FAR_LIMIT);
    pending_samples.push_back(FAR_LIMIT + 1'b1);
    pending_samples.push_back(FAR_LIMIT - 1'b1);
    pending_samples.push_back(16'hAAAA);
    pending_samples.push_back(16'h5555);
    pending_samples.push_back(16'hFFFF);
    pending_samples.push_back(16'h0000);
    pending_samples.push_back(16'h5555);
    repeat (N_SAMPLES) pending_samples.push_back(16'h5555);
    repeat (N_SAMPLES) pending_samples.push_back(16'hFFFF);
    repeat (N_SAMPLES) pending_samples.push_back(16'h0000);

    generated = 0;
    plan_idx = 0;
    break_at = $urandom_range(100, 260);
    while (generated < RANDOM_ITEMS) begin
      style = sweep_style_t'($urandom_range(0, N_STYLES - 1));
      tie_value = DIST_W'($urandom_range(0, FAR_LIMIT));
      for (int k = 0; k < SWEEP_BEATS && generated < RANDOM_ITEMS; k++) begin
        pending_samples.push_back(draw_sample(style, tie_value));
        generated++;
        // Breaks fall anywhere, mid-position included, so new settings also
        // take effect partway through a sweep.
        if (generated == break_at) begin
          break_at += $urandom_range(100, 260);
          wait_until_drained();
          in_gaps_on = ($urandom_range(0, 3) != 0);
          out_stalls_on = ($urandom_range(0, 3) != 0);
          if ($urandom_range(0, 1) != 0)
            write_reg(CFG_IDX_W'($urandom_range(FIRST_UNUSED_REG, LAST_UNUSED_REG)),
                      CFG_DATA_W'($urandom));
          if (plan_idx < N_PLANS) begin
            new_center = center_plan[plan_idx];
            new_span = span_plan[plan_idx];
            plan_idx++;
          end else begin
            new_center = CFG_DATA_W'($urandom);
            new_span = CFG_DATA_W'($urandom);
          end
          write_reg(REG_CENTER_ANGLE, new_center);
          write_reg(REG_SWEEP_HALF_SPAN, new_span);
        end
      end
    end

    wait_until_drained();
    if (error_count == 0 && expected_sweeps.size() == 0) begin
      $display("[median_sweep_nearest_target] OK");
    end else begin
      $display("[median_sweep_nearest_target] ERROR");
    end
    $finish;
  end

endmodule
